[src/shs_pkg.sv]
// ----------------------------------------------------------------------------
// shs_pkg: shared types, constants and mix functions
// Queue entry layout, operation codes and the hash round functions used by
// the front and back parts of the hash stream block.
// ----------------------------------------------------------------------------
package shs_pkg;

   localparam int WORD_W  = 32;
   localparam int LEN_W   = 16;
   localparam int SEED_W  = LEN_W + 1;
   localparam int CNT_W   = 3;
   localparam int REM_W   = 2;
   localparam int TAIL_W  = 24;

   localparam logic [CNT_W-1:0]  FULL_CHUNK  = 3'd4;
   localparam logic [SEED_W-1:0] APPEND_SEED = 17'd4;

   // Operation carried through the queue
   typedef enum logic [1:0] {
      OP_MIX,
      OP_FINAL,
      OP_ZERO
   } op_type;

   typedef struct packed {
      op_type              op;
      logic                first;
      logic [SEED_W-1:0]   seed;
      logic [WORD_W-1:0]   data;
      logic                full;
      logic                app;
      logic [WORD_W-1:0]   run_lo;
      logic [TAIL_W-1:0]   tail;
      logic [REM_W-1:0]    rem;
   } entry_type;

   function automatic logic [WORD_W-1:0] sext8(input logic [7:0] b);
      return {{(WORD_W-8){b[7]}}, b};
   endfunction

   // Chunk mix: one 4-byte word into the running hash
   function automatic logic [WORD_W-1:0] mix_word(input logic [WORD_W-1:0] h,
                                                  input logic [WORD_W-1:0] w);
      logic [WORD_W-1:0] s;
      logic [WORD_W-1:0] t;
      logic [WORD_W-1:0] u;
      s = h + {16'b0, w[15:0]};
      t = {5'b0, w[31:16], 11'b0} ^ s;
      u = (s << 16) ^ t;
      return u + (u >> 11);
   endfunction

   // Remainder mix for 0 to 3 trailing bytes
   function automatic logic [WORD_W-1:0] mix_tail(input logic [WORD_W-1:0] h,
                                                  input logic [TAIL_W-1:0] b,
                                                  input logic [REM_W-1:0]  n);
      logic [WORD_W-1:0] x;
      x = h;
      unique case (n)
         2'd3: begin
            x = x + {16'b0, b[15:0]};
            x = x ^ (x << 16);
            x = x ^ (sext8(b[23:16]) << 18);
            x = x + (x >> 11);
         end
         2'd2: begin
            x = x + {16'b0, b[15:0]};
            x = x ^ (x << 11);
            x = x + (x >> 17);
         end
         2'd1: begin
            x = x + sext8(b[7:0]);
            x = x ^ (x << 10);
            x = x + (x >> 1);
         end
         default: begin
            x = h;
         end
      endcase
      return x;
   endfunction

   // Final avalanche
   function automatic logic [WORD_W-1:0] avalanche(input logic [WORD_W-1:0] h);
      logic [WORD_W-1:0] x;
      x = h;
      x = x ^ (x << 3);
      x = x + (x >> 5);
      x = x ^ (x << 4);
      x = x + (x >> 17);
      x = x ^ (x << 25);
      x = x + (x >> 6);
      return x;
   endfunction

endpackage

[src/shs_req_if.sv]
// ----------------------------------------------------------------------------
// shs_req_if: chunk request channel
// Valid/ready channel carrying one message chunk with its side fields.
// ----------------------------------------------------------------------------
interface shs_req_if;
   logic                          valid;
   logic                          ready;
   logic [shs_pkg::WORD_W-1:0]    chunk_data;
   logic [shs_pkg::CNT_W-1:0]     byte_count;
   logic                          last_chunk;
   logic [shs_pkg::LEN_W-1:0]     msg_length;
   logic                          append_mode;
   logic [shs_pkg::WORD_W-1:0]    append_word;

   modport source (
      output valid, chunk_data, byte_count, last_chunk, msg_length,
             append_mode, append_word,
      input  ready
   );
   modport sink (
      input  valid, chunk_data, byte_count, last_chunk, msg_length,
             append_mode, append_word,
      output ready
   );
endinterface

[src/shs_rsp_if.sv]
// ----------------------------------------------------------------------------
// shs_rsp_if: hash response channel
// Valid/ready channel carrying one finished hash value.
// ----------------------------------------------------------------------------
interface shs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [shs_pkg::WORD_W-1:0]    hash_value;

   modport source (output valid, hash_value, input ready);
   modport sink   (input valid, hash_value, output ready);
endinterface

[src/shs_front.sv]
// ----------------------------------------------------------------------------
// shs_front: chunk classifier
// Tracks message boundaries, computes the seed, and lays out tail and
// append bytes so the back end only runs mixes.
// ----------------------------------------------------------------------------
module shs_front (
   input  logic                 clock,
   input  logic                 reset,
   shs_req_if.sink              req_ch,
   input  logic                 queue_full,
   output logic                 push,
   output shs_pkg::entry_type   entry
);

   logic                         in_msg_ff, in_msg_in;
   logic                         app_ff, app_in;
   logic                         first;
   logic                         zero_msg;
   logic                         app_eff;
   logic [shs_pkg::CNT_W-1:0]    cnt_sat;
   logic [shs_pkg::REM_W-1:0]    rem;
   logic [shs_pkg::TAIL_W-1:0]   tail;
   logic [shs_pkg::TAIL_W-1:0]   run_hi;
   logic [shs_pkg::WORD_W-1:0]   run_lo;
   logic [shs_pkg::WORD_W-1:0]   data;
   logic [shs_pkg::WORD_W-1:0]   aw;

   assign req_ch.ready = !queue_full;
   assign push         = req_ch.valid && !queue_full;

   assign data     = req_ch.chunk_data;
   assign aw       = req_ch.append_word;
   assign first    = !in_msg_ff;
   assign zero_msg = first && (req_ch.msg_length == '0) && !req_ch.append_mode;
   assign app_eff  = first ? req_ch.append_mode : app_ff;

   // Saturate the byte count and split off the remainder
   always_comb begin
      cnt_sat = (req_ch.byte_count > shs_pkg::FULL_CHUNK) ? shs_pkg::FULL_CHUNK
                                                           : req_ch.byte_count;
      rem     = (cnt_sat == shs_pkg::FULL_CHUNK) ? '0 : cnt_sat[shs_pkg::REM_W-1:0];
   end

   // Line up tail bytes followed by the append word
   always_comb begin
      unique case (rem)
         2'd1: begin
            tail   = {16'b0, data[7:0]};
            run_lo = {aw[23:0], data[7:0]};
            run_hi = {16'b0, aw[31:24]};
         end
         2'd2: begin
            tail   = {8'b0, data[15:0]};
            run_lo = {aw[15:0], data[15:0]};
            run_hi = {8'b0, aw[31:16]};
         end
         2'd3: begin
            tail   = data[23:0];
            run_lo = {aw[7:0], data[23:0]};
            run_hi = aw[31:8];
         end
         default: begin
            tail   = '0;
            run_lo = aw;
            run_hi = '0;
         end
      endcase
   end

   // Build the queue entry
   always_comb begin
      if (zero_msg) begin
         entry.op = shs_pkg::OP_ZERO;
      end else if (req_ch.last_chunk) begin
         entry.op = shs_pkg::OP_FINAL;
      end else begin
         entry.op = shs_pkg::OP_MIX;
      end
      entry.first  = first;
      entry.seed   = {1'b0, req_ch.msg_length}
                     + (req_ch.append_mode ? shs_pkg::APPEND_SEED : '0);
      entry.data   = data;
      entry.full   = (cnt_sat == shs_pkg::FULL_CHUNK);
      entry.app    = app_eff;
      entry.run_lo = run_lo;
      entry.tail   = app_eff ? run_hi : tail;
      entry.rem    = rem;
   end

   // Advance message state on each transfer
   always_comb begin
      in_msg_in = in_msg_ff;
      app_in    = app_ff;
      if (push) begin
         if (zero_msg) begin
            in_msg_in = 1'b0;
            app_in    = 1'b0;
         end else begin
            in_msg_in = !req_ch.last_chunk;
            app_in    = req_ch.last_chunk ? 1'b0 : app_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_msg_ff <= 1'b0;
         app_ff    <= 1'b0;
      end else begin
         in_msg_ff <= in_msg_in;
         app_ff    <= app_in;
      end
   end

   a_zero_stays_idle: assert property (@(posedge clock) disable iff (reset)
      push && zero_msg |=> !in_msg_ff && !app_ff)
      else $error("zero-length message left the front in a message");

endmodule

[src/shs_fifo.sv]
// ----------------------------------------------------------------------------
// shs_fifo: entry queue
// Short first-in first-out queue between classifier and mix pipeline.
// ----------------------------------------------------------------------------
module shs_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  shs_pkg::entry_type   push_entry,
   output logic                 full,
   input  logic                 pop,
   output logic                 head_valid,
   output shs_pkg::entry_type   head_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   shs_pkg::entry_type   entries_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = entries_ff[rd_ptr_ff];

   // Wrap pointers and track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries; no reset on payload
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue fill level above depth");

   a_no_empty_pop: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("pop from empty queue");

endmodule

[src/shs_back.sv]
// ----------------------------------------------------------------------------
// shs_back: mix pipeline
// Applies chunk mixes to the running hash and runs the finishing rounds
// (append mix, remainder mix, avalanche) through three stages.
// ----------------------------------------------------------------------------
module shs_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  shs_pkg::entry_type   head_entry,
   output logic                 pop,
   shs_rsp_if.source            rsp_ch
);

   logic [shs_pkg::WORD_W-1:0]   run_ff, run_in;
   logic [shs_pkg::WORD_W-1:0]   h_base;
   logic [shs_pkg::WORD_W-1:0]   h_mixed;
   logic                         advance;
   logic                         is_mix;

   logic                         a_valid_ff;
   logic                         a_zero_ff;
   logic                         a_app_ff;
   logic [shs_pkg::WORD_W-1:0]   a_h_ff;
   logic [shs_pkg::WORD_W-1:0]   a_run_lo_ff;
   logic [shs_pkg::TAIL_W-1:0]   a_tail_ff;
   logic [shs_pkg::REM_W-1:0]    a_rem_ff;

   logic                         b_valid_ff;
   logic                         b_zero_ff;
   logic [shs_pkg::WORD_W-1:0]   b_h_ff;
   logic [shs_pkg::TAIL_W-1:0]   b_tail_ff;
   logic [shs_pkg::REM_W-1:0]    b_rem_ff;

   logic                         c_valid_ff;
   logic                         c_zero_ff;
   logic [shs_pkg::WORD_W-1:0]   c_h_ff;

   logic                         rsp_valid_ff;
   logic [shs_pkg::WORD_W-1:0]   rsp_hash_ff;

   assign advance = !rsp_valid_ff || rsp_ch.ready;
   assign is_mix  = (head_entry.op == shs_pkg::OP_MIX);
   assign pop     = head_valid && (is_mix || advance);

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.hash_value = rsp_hash_ff;

   // Seed on a first chunk, else continue the running hash
   always_comb begin
      h_base  = head_entry.first ? {{(shs_pkg::WORD_W-shs_pkg::SEED_W){1'b0}},
                                     head_entry.seed}
                                 : run_ff;
      h_mixed = shs_pkg::mix_word(h_base, head_entry.data);
      run_in  = run_ff;
      if (pop && is_mix) begin
         run_in = h_mixed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
      end else begin
         run_ff <= run_in;
      end
   end

   // Finishing pipeline; all stages move together when the output is free
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff   <= pop && !is_mix;
         b_valid_ff   <= a_valid_ff;
         c_valid_ff   <= b_valid_ff;
         rsp_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         // stage A: last full chunk
         a_zero_ff   <= (head_entry.op == shs_pkg::OP_ZERO);
         a_app_ff    <= head_entry.app;
         a_h_ff      <= head_entry.full ? h_mixed : h_base;
         a_run_lo_ff <= head_entry.run_lo;
         a_tail_ff   <= head_entry.tail;
         a_rem_ff    <= head_entry.rem;
         // stage B: low word of the appended run
         b_zero_ff   <= a_zero_ff;
         b_h_ff      <= a_app_ff ? shs_pkg::mix_word(a_h_ff, a_run_lo_ff) : a_h_ff;
         b_tail_ff   <= a_tail_ff;
         b_rem_ff    <= a_rem_ff;
         // stage C: remainder bytes
         c_zero_ff   <= b_zero_ff;
         c_h_ff      <= shs_pkg::mix_tail(b_h_ff, b_tail_ff, b_rem_ff);
         // output: avalanche
         rsp_hash_ff <= c_zero_ff ? '0 : shs_pkg::avalanche(c_h_ff);
      end
   end

   a_mix_never_waits: assert property (@(posedge clock) disable iff (reset)
      head_valid && is_mix |-> pop)
      else $error("chunk mix held back by output stall");

   a_stall_freezes_pipe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ch.ready |=>
         $stable({a_valid_ff, b_valid_ff, c_valid_ff, rsp_hash_ff}))
      else $error("finishing pipeline moved during output stall");

endmodule

[src/superfast_hash_stream.sv]
// Path: a chunk transfer is written into the entry queue, then passes stages
//   A, B and C to the output register; output stalls hold the response back.
// Throughput: one chunk per cycle unless the entry queue is full, set by the
//   chunk mix loop on the running hash; the queue absorbs output stalls.
// Reset: synchronous, clears message state, queue and pipeline valid bits.
// ----------------------------------------------------------------------------
// superfast_hash_stream: streaming 32-bit SuperFastHash
// Classifier front, entry queue and mix pipeline back end.
// ----------------------------------------------------------------------------
module superfast_hash_stream #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   shs_req_if.sink     req_ch,
   shs_rsp_if.source   rsp_ch
);

   shs_pkg::entry_type   push_entry;
   shs_pkg::entry_type   head_entry;
   logic                 push;
   logic                 queue_full;
   logic                 pop;
   logic                 head_valid;

   shs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .push       (push),
      .entry      (push_entry)
   );

   shs_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   shs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );

endmodule
